// File: hdl/qmn_pkg.sv
// ----------------------------------------------------------------------------
// qmn_pkg
// Shared widths, types and constants for the normalized quaternion product.
// ----------------------------------------------------------------------------
package qmn_pkg;

    localparam int COMP_W  = 16;            // Q2.14 component width
    localparam int NCOMP   = 4;             // x, y, z, w
    localparam int PROD_W  = 32;            // one 16x16 product
    localparam int SUM_W   = 35;            // sum of four products, signed
    localparam int MAG_W   = 31;            // magnitude of the Q4.26 value
    localparam int SQR_W   = 2 * MAG_W;     // one squared magnitude
    localparam int S_W     = 64;            // sum of squares and its remainder
    localparam int ROOT_W  = 31;            // floor(sqrt(S))
    localparam int QUO_W   = 15;            // scaled component magnitude
    localparam int FRAC_SH = 15;            // Q14 scale plus one for rounding
    localparam int NUM_W   = 48;            // dividend of the scaling step
    localparam int LEN_W   = 16;            // threshold register width
    localparam int THR_W   = 28;            // threshold shifted to Q4.26
    localparam int THRSQ_W = 2 * THR_W;     // squared threshold

    localparam int QMN_FIFO_DEPTH = 4;

    localparam logic [LEN_W-1:0]  MIN_LENGTH_RST = 16'd1;
    localparam logic [COMP_W-1:0] ONE_Q14        = 16'sd16384;
    localparam logic [NCOMP*COMP_W-1:0] IDENT_WORD = {ONE_Q14, {3*COMP_W{1'b0}}};

    // Component slots inside an item.
    localparam int CX = 0;
    localparam int CY = 1;
    localparam int CZ = 2;
    localparam int CW = 3;

    // One classified product waiting for normalization.
    typedef struct packed {
        logic [S_W-1:0]               sumsq;
        logic [NCOMP-1:0][MAG_W-1:0]  mag;
        logic [NCOMP-1:0]             neg;
        logic                         degen;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// File: hdl/qmn_fifo.sv
// ----------------------------------------------------------------------------
// qmn_fifo
// Short queue that decouples the product front end from the normalizer.
// ----------------------------------------------------------------------------
module qmn_fifo
    import qmn_pkg::*;
#(
    parameter int DEPTH = QMN_FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  item_t      din,
    input  logic       pop,
    output item_t      dout,
    output fifo_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    assign dout       = mem[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

// File: hdl/qmn_front.sv
// ----------------------------------------------------------------------------
// qmn_front
// Forms the Hamilton product, its squared length, and the degenerate flag.
// ----------------------------------------------------------------------------
module qmn_front
    import qmn_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [2*NCOMP*COMP_W-1:0]   s_tdata,
    input  logic [THRSQ_W-1:0]          thr_sq,
    input  logic                        fifo_full,
    output logic                        push,
    output item_t                       item
);

    logic signed [COMP_W-1:0] a [NCOMP];
    logic signed [COMP_W-1:0] b [NCOMP];

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [PROD_W-1:0] prod_reg [NCOMP][4];
    logic signed [PROD_W-1:0] prod_next [NCOMP][4];
    logic signed [SUM_W-1:0]  p_sum [NCOMP];
    logic signed [SUM_W-1:0]  q_val [NCOMP];
    logic [SUM_W-1:0]         q_abs [NCOMP];
    logic [MAG_W-1:0]         mag2_reg [NCOMP];
    logic [NCOMP-1:0]         neg2_reg, neg3_reg;
    logic [MAG_W-1:0]         mag3_reg [NCOMP];
    logic [SQR_W-1:0]         sq3_reg [NCOMP];
    logic [S_W-1:0]           sumsq;
    item_t                    item_reg;
    logic                     adv;

    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            a[c] = s_tdata[c*COMP_W +: COMP_W];
            b[c] = s_tdata[(NCOMP+c)*COMP_W +: COMP_W];
        end
    end

    // The whole front advances together; it holds while its last stage
    // cannot drop into the queue.
    assign adv      = !v4_reg || !fifo_full;
    assign s_tready = adv;
    assign push     = v4_reg && !fifo_full;
    assign item     = item_reg;

    // Products grouped so that each component is p0 + p1 + p2 - p3,
    // except w, which is p0 - p1 - p2 - p3.
    always_comb begin
        prod_next[CX][0] = a[CX] * b[CW];
        prod_next[CX][1] = b[CX] * a[CW];
        prod_next[CX][2] = a[CY] * b[CZ];
        prod_next[CX][3] = a[CZ] * b[CY];
        prod_next[CY][0] = a[CY] * b[CW];
        prod_next[CY][1] = b[CY] * a[CW];
        prod_next[CY][2] = a[CZ] * b[CX];
        prod_next[CY][3] = a[CX] * b[CZ];
        prod_next[CZ][0] = a[CZ] * b[CW];
        prod_next[CZ][1] = b[CZ] * a[CW];
        prod_next[CZ][2] = a[CX] * b[CY];
        prod_next[CZ][3] = a[CY] * b[CX];
        prod_next[CW][0] = a[CW] * b[CW];
        prod_next[CW][1] = a[CX] * b[CX];
        prod_next[CW][2] = a[CY] * b[CY];
        prod_next[CW][3] = a[CZ] * b[CZ];
    end

    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            if (c == CW) begin
                p_sum[c] = SUM_W'(prod_reg[c][0]) - SUM_W'(prod_reg[c][1])
                         - SUM_W'(prod_reg[c][2]) - SUM_W'(prod_reg[c][3]);
            end else begin
                p_sum[c] = SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1])
                         + SUM_W'(prod_reg[c][2]) - SUM_W'(prod_reg[c][3]);
            end
            // Divide by four, truncating toward zero.
            q_val[c] = (p_sum[c] + (p_sum[c][SUM_W-1] ? SUM_W'(3) : SUM_W'(0))) >>> 2;
            q_abs[c] = q_val[c][SUM_W-1] ? SUM_W'(-q_val[c]) : SUM_W'(q_val[c]);
        end
        sumsq = '0;
        for (int c = 0; c < NCOMP; c++) begin
            sumsq = sumsq + S_W'(sq3_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            for (int c = 0; c < NCOMP; c++) begin
                mag2_reg[c] <= q_abs[c][MAG_W-1:0];
                neg2_reg[c] <= q_val[c][SUM_W-1];
                mag3_reg[c] <= mag2_reg[c];
                sq3_reg[c]  <= mag2_reg[c] * mag2_reg[c];
                item_reg.mag[c] <= mag3_reg[c];
            end
            neg3_reg       <= neg2_reg;
            item_reg.neg   <= neg3_reg;
            item_reg.sumsq <= sumsq;
            item_reg.degen <= (sumsq <= S_W'(thr_sq));
        end
    end

endmodule

// File: hdl/qmn_back.sv
// ----------------------------------------------------------------------------
// qmn_back
// Normalizer: pipelined square root, then pipelined scaling division.
// ----------------------------------------------------------------------------
module qmn_back
    import qmn_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  item_t                       item,
    input  logic                        fifo_empty,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [NCOMP*COMP_W-1:0]     m_tdata,
    output logic                        m_tuser
);

    localparam int SQ_N = ROOT_W;
    localparam int DV_N = QUO_W;

    logic adv;

    // Square-root pipeline: entry 0 holds the item taken from the queue.
    logic [SQ_N:0]            sv_reg;
    logic [S_W-1:0]           rem_reg  [SQ_N+1];
    logic [ROOT_W-1:0]        root_reg [SQ_N+1];
    logic [MAG_W-1:0]         smag_reg [SQ_N+1][NCOMP];
    logic [NCOMP-1:0]         sneg_reg [SQ_N+1];
    logic [SQ_N:0]            sdeg_reg;
    logic [S_W-1:0]           rem_next  [SQ_N];
    logic [ROOT_W-1:0]        root_next [SQ_N];

    // Division pipeline: entry 0 holds the set-up dividends.
    logic [DV_N:0]            dv_reg;
    logic [NUM_W-1:0]         num_reg [DV_N+1][NCOMP];
    logic [NUM_W-1:0]         den_reg [DV_N+1];
    logic [QUO_W-1:0]         quo_reg [DV_N+1][NCOMP];
    logic [NCOMP-1:0]         dneg_reg [DV_N+1];
    logic [DV_N:0]            ddeg_reg;
    logic [NUM_W-1:0]         num_next [DV_N][NCOMP];
    logic [QUO_W-1:0]         quo_next [DV_N][NCOMP];

    logic                     out_v_reg;
    logic [NCOMP*COMP_W-1:0]  out_data_reg, out_data_next;
    logic                     out_deg_reg;

    assign adv      = !out_v_reg || m_tready;
    assign pop      = adv && !fifo_empty;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_deg_reg;

    // One root bit per stage, most significant first.
    always_comb begin
        logic [S_W-1:0] trial;
        for (int j = 0; j < SQ_N; j++) begin
            trial = (S_W'(root_reg[j]) << (ROOT_W - j))
                  + (S_W'(1) << (2 * (ROOT_W - 1 - j)));
            if (rem_reg[j] >= trial) begin
                rem_next[j]  = rem_reg[j] - trial;
                root_next[j] = root_reg[j] | (ROOT_W'(1) << (ROOT_W - 1 - j));
            end else begin
                rem_next[j]  = rem_reg[j];
                root_next[j] = root_reg[j];
            end
        end
    end

    // One quotient bit per stage for each component; quotients stay below
    // 2^QUO_W since no component exceeds the length.
    always_comb begin
        logic [NUM_W-1:0] dsh;
        for (int j = 0; j < DV_N; j++) begin
            dsh = den_reg[j] << (QUO_W - 1 - j);
            for (int c = 0; c < NCOMP; c++) begin
                if (num_reg[j][c] >= dsh) begin
                    num_next[j][c] = num_reg[j][c] - dsh;
                    quo_next[j][c] = quo_reg[j][c] | (QUO_W'(1) << (QUO_W - 1 - j));
                end else begin
                    num_next[j][c] = num_reg[j][c];
                    quo_next[j][c] = quo_reg[j][c];
                end
            end
        end
    end

    always_comb begin
        logic [COMP_W-1:0] mag;
        for (int c = 0; c < NCOMP; c++) begin
            mag = COMP_W'(quo_reg[DV_N][c]);
            out_data_next[c*COMP_W +: COMP_W] = dneg_reg[DV_N][c] ? -mag : mag;
        end
        if (ddeg_reg[DV_N]) begin
            out_data_next = IDENT_WORD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg    <= '0;
            dv_reg    <= '0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            sv_reg    <= {sv_reg[SQ_N-1:0], !fifo_empty};
            dv_reg    <= {dv_reg[DV_N-1:0], sv_reg[SQ_N]};
            out_v_reg <= dv_reg[DV_N];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= item.sumsq;
            root_reg[0] <= '0;
            for (int c = 0; c < NCOMP; c++) begin
                smag_reg[0][c] <= item.mag[c];
            end
            sneg_reg[0] <= item.neg;
            sdeg_reg[0] <= item.degen;
            for (int j = 0; j < SQ_N; j++) begin
                rem_reg[j+1]  <= rem_next[j];
                root_reg[j+1] <= root_next[j];
                smag_reg[j+1] <= smag_reg[j];
                sneg_reg[j+1] <= sneg_reg[j];
                sdeg_reg[j+1] <= sdeg_reg[j];
            end

            // (mag * 2^15 + len) / (2 * len) rounds mag * 2^14 / len.
            for (int c = 0; c < NCOMP; c++) begin
                num_reg[0][c] <= (NUM_W'(smag_reg[SQ_N][c]) << FRAC_SH)
                               + NUM_W'(root_reg[SQ_N]);
                quo_reg[0][c] <= '0;
            end
            den_reg[0]  <= NUM_W'(root_reg[SQ_N]) << 1;
            dneg_reg[0] <= sneg_reg[SQ_N];
            ddeg_reg[0] <= sdeg_reg[SQ_N];
            for (int j = 0; j < DV_N; j++) begin
                num_reg[j+1]  <= num_next[j];
                quo_reg[j+1]  <= quo_next[j];
                den_reg[j+1]  <= den_reg[j];
                dneg_reg[j+1] <= dneg_reg[j];
                ddeg_reg[j+1] <= ddeg_reg[j];
            end

            out_data_reg <= out_data_next;
            out_deg_reg  <= ddeg_reg[DV_N];
        end
    end

endmodule

// File: hdl/quaternion_multiply_normalize.sv
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize
// Hamilton product of two Q2.14 quaternions, scaled to unit length.
// ----------------------------------------------------------------------------
// The block takes one word per clock and returns one word per clock for as
// long as the result side keeps taking them. Each input word carries two
// quaternions; each result word carries their Hamilton product scaled to unit
// length in Q2.14, rounded to nearest with ties away from zero. When the
// product's length is at or below min_length (in Q2.14 LSBs) the identity
// quaternion is returned and tuser is set. From acceptance, four stages form
// the product and its squared length, the word passes the queue, 31 stages
// take the square root one bit each, 15 stages do the scaling division one
// quotient bit each, and the root entry, division set-up and output
// registers frame those. A small queue sits between the product front end
// and the normalizer, so either side may stall alone.
// min_length may be written only while no word is in flight; its square is
// registered from the min_length register.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize
    import qmn_pkg::*;
#(
    parameter int FIFO_DEPTH = QMN_FIFO_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    // lhs_x, lhs_y, lhs_z, lhs_w, rhs_x, rhs_y, rhs_z, rhs_w (16 bits each)
    input  logic [2*NCOMP*COMP_W-1:0]   s_tdata,

    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_x, out_y, out_z, out_w (16 bits each)
    output logic [NCOMP*COMP_W-1:0]     m_tdata,
    // was_degenerate
    output logic                        m_tuser,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [LEN_W-1:0]            cfg_data
);

    logic [LEN_W-1:0]   min_length_reg;
    logic [THRSQ_W-1:0] thr_sq_reg;
    logic [THR_W-1:0]   thr;
    logic               front_push;
    item_t              front_item;
    item_t              queue_item;
    logic               back_pop;
    fifo_stat_t         fifo_stat;

    // The register is always writable.
    assign cfg_ready = 1'b1;
    assign thr       = {min_length_reg, 12'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg <= MIN_LENGTH_RST;
            thr_sq_reg     <= THRSQ_W'(1) << 24;
        end else begin
            if (cfg_valid) begin
                min_length_reg <= cfg_data;
            end
            thr_sq_reg <= thr * thr;
        end
    end

    // Front end: product, squared length and the threshold compare.
    qmn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .thr_sq    (thr_sq_reg),
        .fifo_full (fifo_stat.full),
        .push      (front_push),
        .item      (front_item)
    );

    qmn_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (front_push),
        .din     (front_item),
        .pop     (back_pop),
        .dout    (queue_item),
        .stat    (fifo_stat)
    );

    // Back end: square root, division and the output register.
    qmn_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (queue_item),
        .fifo_empty (fifo_stat.empty),
        .pop        (back_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

`ifndef SYNTH
    // The front end never drops a word into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_stat.full |-> !front_push)
        else $error("push into full queue");

    // The normalizer never takes a word from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_stat.empty |-> !back_pop)
        else $error("pop from empty queue");

    // A degenerate result always carries the identity quaternion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == IDENT_WORD))
        else $error("degenerate result is not the identity");

    // A register write lands on the next edge.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> (min_length_reg == $past(cfg_data)))
        else $error("threshold write lost");
`endif

endmodule
